>>> hdl/mrh64_pkg.sv
// Shared types, constants and mixing functions of the multiply-rotate 64-bit hash.
package mrh64_pkg;

  // Multiplier constants of the mixers.
  localparam logic [63:0] K_MAIN = 64'hBEA2_25F9_EB34_556D;
  localparam logic [63:0] K_Q    = 64'hD1B9_2B09_B922_66DD;
  localparam logic [63:0] K_R    = 64'h9995_988B_72E0_D285;
  localparam logic [63:0] K_S    = 64'h8FAD_F5E2_86E3_1587;
  localparam logic [63:0] K_T    = 64'hFCF8_B405_D3D0_783B;

  // Configuration register indexes.
  localparam logic [0:0] REG_SEED = 1'b0;
  localparam logic [0:0] REG_SWAP = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BPRE,
    ST_BULK,
    ST_W1,
    ST_W2,
    ST_W3,
    ST_FPREP,
    ST_FMUL,
    ST_EMIT
  } st_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] p;
  } mul_rsp_t;

  // Rotate left by a constant amount between 1 and 63.
  function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned r);
    return (x << r) | (x >> (64 - r));
  endfunction

  function automatic logic [63:0] swap64(input logic [63:0] x);
    logic [63:0] y;
    for (int i = 0; i < 8; i++) begin
      y[8*(7-i) +: 8] = x[8*i +: 8];
    end
    return y;
  endfunction

  function automatic logic [63:0] init_hash(input logic [31:0] len, input logic [63:0] seed);
    return {32'b0, len} ^ seed ^ rotl(seed, 29) ^ rotl(seed, 47);
  endfunction

  function automatic logic [63:0] pre_mix(input logic [63:0] x);
    return x ^ rotl(x, 23) ^ rotl(x, 43);
  endfunction

  function automatic logic [63:0] post_mix(input logic [63:0] x);
    return x ^ rotl(x, 11) ^ rotl(x, 50);
  endfunction

  // Tail value from the first r valid bytes. In swapped order the bytes are taken
  // as 16- and 32-bit big-endian groups, a lone odd byte stays in place.
  function automatic logic [63:0] tail_value(input logic [63:0] raw, input logic [2:0] r,
                                             input logic sw);
    logic [7:0] b0, b1, b2, b3, b4, b5, b6;
    logic [63:0] v;
    b0 = raw[7:0];
    b1 = raw[15:8];
    b2 = raw[23:16];
    b3 = raw[31:24];
    b4 = raw[39:32];
    b5 = raw[47:40];
    b6 = raw[55:48];
    if (sw) begin
      unique case (r)
        3'd1: v = {56'b0, b0};
        3'd2: v = {48'b0, b0, b1};
        3'd3: v = {40'b0, b2, b0, b1};
        3'd4: v = {32'b0, b0, b1, b2, b3};
        3'd5: v = {24'b0, b4, b0, b1, b2, b3};
        3'd6: v = {16'b0, b4, b5, b0, b1, b2, b3};
        3'd7: v = {8'b0, b6, b4, b5, b0, b1, b2, b3};
        3'd0: v = '0;
      endcase
    end else begin
      unique case (r)
        3'd1: v = {56'b0, raw[7:0]};
        3'd2: v = {48'b0, raw[15:0]};
        3'd3: v = {40'b0, raw[23:0]};
        3'd4: v = {32'b0, raw[31:0]};
        3'd5: v = {24'b0, raw[39:0]};
        3'd6: v = {16'b0, raw[47:0]};
        3'd7: v = {8'b0, raw[55:0]};
        3'd0: v = '0;
      endcase
    end
    return v;
  endfunction

endpackage

>>> hdl/mrh64_mul.sv
// Iterative 64x64 multiplier (low 64 bits) built on one shared 32x32 multiplier.
module mrh64_mul (
  input  logic                clk,
  input  logic                rst_n,
  input  mrh64_pkg::mul_req_t req,
  output mrh64_pkg::mul_rsp_t rsp
);

  logic [63:0] a_r;
  logic [63:0] b_r;
  logic [1:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [63:0] prod_r;
  logic [63:0] sum_r;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [63:0] mprod;

  // Partial products: low x low, then the two cross terms shifted up by 32.
  always_comb begin
    unique case (cnt_r)
      2'd0: begin
        op_a = a_r[31:0];
        op_b = b_r[31:0];
      end
      2'd1: begin
        op_a = a_r[31:0];
        op_b = b_r[63:32];
      end
      default: begin
        op_a = a_r[63:32];
        op_b = b_r[31:0];
      end
    endcase
  end

  assign mprod = {32'b0, op_a} * {32'b0, op_b};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      a_r <= req.a;
      b_r <= req.b;
    end
    if (busy_r) begin
      prod_r <= (cnt_r == 2'd0) ? mprod : {mprod[31:0], 32'b0};
      sum_r  <= (cnt_r == 2'd1) ? prod_r : sum_r + prod_r;
    end
  end

  assign rsp.done = done_r;
  assign rsp.p    = sum_r;

endmodule

>>> hdl/multiply_rotate_hash_64.sv
// Top level of the multiply-rotate 64-bit hash: word sequencer, state and ports.
// A word buffered into a half-block is only stored; a word closing a first half goes through
// ST_BPRE and ST_BULK, a second half ST_BULK, a single or tail word ST_W1 to ST_W3; the last
// word adds ST_FPREP, ST_FMUL and ST_EMIT for the final mix. Each multiplication holds the
// shared unit from issue to done. One word at a time: in_stall is high outside ST_IDLE.
// Reset (synchronous, rst_n low) clears the seed, swap flag, counters and output valid.
module multiply_rotate_hash_64 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write_en,
  input  logic [0:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_data_word,
  input  logic [31:0] in_msg_length,
  input  logic        in_first_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_hash_value
);

  mrh64_pkg::st_t      state_r, state_nxt;
  mrh64_pkg::mul_req_t mul_req;
  mrh64_pkg::mul_rsp_t mul_rsp;

  logic        issued_r, issued_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [31:0] bytes_left_r, bytes_nxt;
  logic [31:0] bulk_left_r, bulk_nxt;
  logic [1:0]  slot_r, slot_nxt;
  logic        second_r, second_nxt;
  logic        in_msg_r, in_msg_nxt;
  logic [63:0] x_r, x_nxt;
  logic [1:0]  step_r, step_nxt;
  logic [63:0] hb_r [3];
  logic        hb_we;
  logic [63:0] seed_r;
  logic        swap_r;
  logic        out_valid_r;
  logic [63:0] out_hash_r;
  logic        out_load;

  // Values the accepted word sees: a first word restarts the message state.
  logic [63:0] init_val;
  logic [63:0] eff_acc;
  logic [31:0] eff_bytes;
  logic [31:0] eff_bulk;
  logic [1:0]  eff_slot;
  logic        eff_second;
  logic [63:0] word_in;
  logic [63:0] bulk_diff;
  logic [63:0] bulk_k;

  assign init_val   = mrh64_pkg::init_hash(in_msg_length, seed_r);
  assign eff_acc    = in_first_word ? init_val : acc_r;
  assign eff_bytes  = in_first_word ? in_msg_length : bytes_left_r;
  assign eff_bulk   = in_first_word ? {in_msg_length[31:6], 6'b0} : bulk_left_r;
  assign eff_slot   = in_first_word ? 2'd0 : slot_r;
  assign eff_second = in_first_word ? 1'b0 : second_r;
  assign word_in    = swap_r ? mrh64_pkg::swap64(in_data_word) : in_data_word;

  assign in_stall = (state_r != mrh64_pkg::ST_IDLE);

  // One term of the half-block mixer per step; words a, b, c are buffered, d is in x_r.
  always_comb begin
    unique case (step_r)
      2'd0: begin
        bulk_diff = mrh64_pkg::rotl(hb_r[0], 29) - hb_r[2];
        bulk_k    = mrh64_pkg::K_Q;
      end
      2'd1: begin
        bulk_diff = mrh64_pkg::rotl(hb_r[1], 29) - x_r;
        bulk_k    = mrh64_pkg::K_R;
      end
      2'd2: begin
        bulk_diff = mrh64_pkg::rotl(hb_r[2], 29) - hb_r[1];
        bulk_k    = mrh64_pkg::K_S;
      end
      2'd3: begin
        bulk_diff = mrh64_pkg::rotl(x_r, 29) - hb_r[0];
        bulk_k    = mrh64_pkg::K_T;
      end
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    issued_nxt = issued_r;
    acc_nxt    = acc_r;
    bytes_nxt  = bytes_left_r;
    bulk_nxt   = bulk_left_r;
    slot_nxt   = slot_r;
    second_nxt = second_r;
    in_msg_nxt = in_msg_r;
    x_nxt      = x_r;
    step_nxt   = step_r;
    hb_we      = 1'b0;
    out_load   = 1'b0;
    mul_req.start = 1'b0;
    mul_req.a     = acc_r;
    mul_req.b     = mrh64_pkg::K_MAIN;

    unique case (state_r)
      mrh64_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_first_word) begin
            acc_nxt    = init_val;
            bytes_nxt  = in_msg_length;
            bulk_nxt   = eff_bulk;
            slot_nxt   = 2'd0;
            second_nxt = 1'b0;
            in_msg_nxt = 1'b1;
          end
          if (in_first_word && (in_msg_length == '0)) begin
            // An empty message is finished by its first word alone.
            in_msg_nxt = 1'b0;
            state_nxt  = mrh64_pkg::ST_FPREP;
          end else if (in_first_word || in_msg_r) begin
            if (eff_bulk != '0) begin
              bulk_nxt  = eff_bulk - 32'd8;
              bytes_nxt = eff_bytes - 32'd8;
              if (eff_slot != 2'd3) begin
                hb_we    = 1'b1;
                slot_nxt = eff_slot + 2'd1;
                state_nxt = (bytes_nxt == '0) ? mrh64_pkg::ST_FPREP : mrh64_pkg::ST_IDLE;
              end else begin
                x_nxt      = word_in;
                slot_nxt   = 2'd0;
                second_nxt = !eff_second;
                step_nxt   = 2'd0;
                if (eff_second) begin
                  acc_nxt   = mrh64_pkg::rotl(eff_acc, 37);
                  state_nxt = mrh64_pkg::ST_BULK;
                end else begin
                  state_nxt = mrh64_pkg::ST_BPRE;
                end
              end
            end else if (|eff_bytes[31:3]) begin
              x_nxt     = word_in;
              bytes_nxt = eff_bytes - 32'd8;
              state_nxt = mrh64_pkg::ST_W1;
            end else begin
              x_nxt     = mrh64_pkg::tail_value(in_data_word, eff_bytes[2:0], swap_r);
              bytes_nxt = '0;
              state_nxt = mrh64_pkg::ST_W1;
            end
            in_msg_nxt = (bytes_nxt != '0);
          end
        end
      end
      mrh64_pkg::ST_BPRE: begin
        mul_req.start = !issued_r;
        issued_nxt    = !mul_rsp.done;
        if (mul_rsp.done) begin
          acc_nxt   = mul_rsp.p;
          state_nxt = mrh64_pkg::ST_BULK;
        end
      end
      mrh64_pkg::ST_BULK: begin
        mul_req.start = !issued_r;
        mul_req.a     = bulk_diff;
        mul_req.b     = bulk_k;
        issued_nxt    = !mul_rsp.done;
        if (mul_rsp.done) begin
          acc_nxt  = acc_r + mul_rsp.p;
          step_nxt = step_r + 2'd1;
          if (step_r == 2'd3) begin
            state_nxt = (bytes_left_r == '0) ? mrh64_pkg::ST_FPREP : mrh64_pkg::ST_IDLE;
          end
        end
      end
      mrh64_pkg::ST_W1: begin
        mul_req.start = !issued_r;
        mul_req.a     = x_r;
        issued_nxt    = !mul_rsp.done;
        if (mul_rsp.done) begin
          x_nxt     = mul_rsp.p ^ (mul_rsp.p >> 39);
          state_nxt = mrh64_pkg::ST_W2;
        end
      end
      mrh64_pkg::ST_W2: begin
        mul_req.start = !issued_r;
        mul_req.a     = x_r;
        issued_nxt    = !mul_rsp.done;
        if (mul_rsp.done) begin
          acc_nxt   = acc_r + mul_rsp.p;
          state_nxt = mrh64_pkg::ST_W3;
        end
      end
      mrh64_pkg::ST_W3: begin
        mul_req.start = !issued_r;
        issued_nxt    = !mul_rsp.done;
        if (mul_rsp.done) begin
          acc_nxt   = mul_rsp.p;
          state_nxt = (bytes_left_r == '0) ? mrh64_pkg::ST_FPREP : mrh64_pkg::ST_IDLE;
        end
      end
      mrh64_pkg::ST_FPREP: begin
        x_nxt     = mrh64_pkg::pre_mix(acc_r);
        state_nxt = mrh64_pkg::ST_FMUL;
      end
      mrh64_pkg::ST_FMUL: begin
        mul_req.start = !issued_r;
        mul_req.a     = x_r;
        issued_nxt    = !mul_rsp.done;
        if (mul_rsp.done) begin
          x_nxt     = mrh64_pkg::post_mix(mul_rsp.p);
          state_nxt = mrh64_pkg::ST_EMIT;
        end
      end
      mrh64_pkg::ST_EMIT: begin
        // Wait until the output register is free or being emptied.
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = mrh64_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mrh64_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mrh64_pkg::ST_IDLE;
      issued_r     <= 1'b0;
      acc_r        <= '0;
      bytes_left_r <= '0;
      bulk_left_r  <= '0;
      slot_r       <= '0;
      second_r     <= 1'b0;
      in_msg_r     <= 1'b0;
      step_r       <= '0;
      seed_r       <= '0;
      swap_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      issued_r     <= issued_nxt;
      acc_r        <= acc_nxt;
      bytes_left_r <= bytes_nxt;
      bulk_left_r  <= bulk_nxt;
      slot_r       <= slot_nxt;
      second_r     <= second_nxt;
      in_msg_r     <= in_msg_nxt;
      step_r       <= step_nxt;
      if (cfg_write_en) begin
        if (cfg_index == mrh64_pkg::REG_SEED) begin
          seed_r <= cfg_data;
        end else begin
          swap_r <= cfg_data[0];
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: the working word, the half-block buffer and the output word.
  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    if (hb_we) begin
      hb_r[eff_slot] <= word_in;
    end
    if (out_load) begin
      out_hash_r <= x_r;
    end
  end

  mrh64_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

`ifndef SYNTHESIS
  a_emit_ends_msg: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mrh64_pkg::ST_EMIT |-> (bytes_left_r == '0) && !in_msg_r)
    else $error("final mix reached with message bytes still pending");

  a_mul_done_owned: assert property (@(posedge clk) disable iff (!rst_n)
    mul_rsp.done |-> issued_r && (state_r == mrh64_pkg::ST_BPRE ||
      state_r == mrh64_pkg::ST_BULK || state_r == mrh64_pkg::ST_W1 ||
      state_r == mrh64_pkg::ST_W2 || state_r == mrh64_pkg::ST_W3 ||
      state_r == mrh64_pkg::ST_FMUL))
    else $error("multiplier finished with no operation waiting for it");

  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == mrh64_pkg::ST_EMIT))
    else $error("output word raised outside the emit state");

  a_idle_no_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mrh64_pkg::ST_IDLE) && !in_msg_r |-> bytes_left_r == '0)
    else $error("idle outside a message with bytes still counted");
`endif

endmodule

>>> test/mrh64_hash_checker.sv
// Checker of the multiply-rotate 64-bit hash: predicts each hash and compares it with the output.
module mrh64_hash_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write_en,
  input  logic [0:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [63:0] in_data_word,
  input  logic [31:0] in_msg_length,
  input  logic        in_first_word,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] out_hash_value,
  output int          errors,
  output int          hashes_due
);

  // Shadow copy of the configuration, as last written on the port.
  logic [63:0] seed_q;
  logic        swap_q;

  // Shadow copy of the message state.
  logic [63:0] acc;
  logic [31:0] left;
  logic [31:0] bulk_left;
  logic [63:0] half_buf [3];
  logic [1:0]  slot;
  logic        upper_half;
  logic        busy;

  // Hashes that completed messages must still produce, oldest first.
  logic [63:0] hash_queue [$];

  function automatic logic [63:0] rol(input logic [63:0] x, input int r);
    logic [127:0] t;
    t = {x, x} << r;
    return t[127:64];
  endfunction

  function automatic logic [63:0] byte_rev(input logic [63:0] x);
    logic [63:0] y;
    for (int i = 0; i < 8; i++) begin
      y[8*i +: 8] = x[8*(7-i) +: 8];
    end
    return y;
  endfunction

  function automatic logic [63:0] finalize(input logic [63:0] x);
    logic [63:0] m;
    m = (x ^ rol(x, 23) ^ rol(x, 43)) * mrh64_pkg::K_MAIN;
    return m ^ rol(m, 11) ^ rol(m, 50);
  endfunction

  function automatic logic [63:0] fold_word(input logic [63:0] h, input logic [63:0] x);
    logic [63:0] m;
    m = x * mrh64_pkg::K_MAIN;
    m = m ^ (m >> 39);
    return (h + m * mrh64_pkg::K_MAIN) * mrh64_pkg::K_MAIN;
  endfunction

  function automatic logic [63:0] fold_half(input logic [63:0] h, input logic [63:0] a,
                                            input logic [63:0] b, input logic [63:0] c,
                                            input logic [63:0] d);
    return h + (rol(a, 29) - c) * mrh64_pkg::K_Q + (rol(b, 29) - d) * mrh64_pkg::K_R
             + (rol(c, 29) - b) * mrh64_pkg::K_S + (rol(d, 29) - a) * mrh64_pkg::K_T;
  endfunction

  // Value of the last 1 to 7 message bytes. Byte-swapped words are read as big-endian
  // pairs and quads, with an odd last byte left where it is.
  function automatic logic [63:0] tail_bytes(input logic [63:0] raw, input logic [2:0] n,
                                             input logic sw);
    logic [7:0]  b [8];
    logic [31:0] quad;
    logic [15:0] pair;
    logic [63:0] v;
    for (int i = 0; i < 8; i++) begin
      b[i] = raw[8*i +: 8];
    end
    quad = {b[0], b[1], b[2], b[3]};
    pair = {b[4], b[5]};
    v = '0;
    if (!sw) begin
      v = raw & ((64'd1 << (8 * n)) - 64'd1);
    end else begin
      case (n)
        3'd1: v = {56'b0, b[0]};
        3'd2: v = {48'b0, b[0], b[1]};
        3'd3: v = {40'b0, b[2], b[0], b[1]};
        3'd4: v = {32'b0, quad};
        3'd5: v = {24'b0, b[4], quad};
        3'd6: v = {16'b0, pair, quad};
        3'd7: v = {8'b0, b[6], pair, quad};
        default: v = '0;
      endcase
    end
    return v;
  endfunction

  task automatic take_word(input logic [63:0] raw, input logic [31:0] len, input logic first);
    logic [63:0] w;
    if (first) begin
      acc = {32'b0, len} ^ seed_q ^ rol(seed_q, 29) ^ rol(seed_q, 47);
      left = len;
      bulk_left = len & ~32'd63;
      slot = '0;
      upper_half = 1'b0;
      if (len == 32'd0) begin
        busy = 1'b0;
        hash_queue.push_back(finalize(acc));
        return;
      end
      busy = 1'b1;
    end else if (!busy) begin
      return;
    end
    w = swap_q ? byte_rev(raw) : raw;
    if (bulk_left >= 32'd8) begin
      if (slot < 2'd3) begin
        half_buf[slot] = w;
        slot = slot + 2'd1;
      end else begin
        acc = fold_half(upper_half ? rol(acc, 37) : acc * mrh64_pkg::K_MAIN,
                        half_buf[0], half_buf[1], half_buf[2], w);
        upper_half = ~upper_half;
        slot = '0;
      end
      bulk_left = bulk_left - 32'd8;
      left = left - 32'd8;
    end else if (left >= 32'd8) begin
      acc = fold_word(acc, w);
      left = left - 32'd8;
    end else begin
      acc = fold_word(acc, tail_bytes(raw, left[2:0], swap_q));
      left = '0;
    end
    if (left == 32'd0) begin
      busy = 1'b0;
      hash_queue.push_back(finalize(acc));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      seed_q = '0;
      swap_q = 1'b0;
      acc = '0;
      left = '0;
      bulk_left = '0;
      slot = '0;
      upper_half = 1'b0;
      busy = 1'b0;
      hash_queue.delete();
      errors = 0;
      hashes_due = 0;
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          mrh64_pkg::REG_SEED: seed_q = cfg_data;
          mrh64_pkg::REG_SWAP: swap_q = cfg_data[0];
          default: ;
        endcase
      end
      // The output is checked before the input is taken, since a word cannot finish
      // a hash in the cycle it is accepted.
      if (out_valid && !out_stall) begin
        if (hash_queue.size() == 0) begin
          $error("hash_value: expected no word, actual %h", out_hash_value);
          errors++;
        end else begin
          if (out_hash_value !== hash_queue[0]) begin
            $error("hash_value: expected %h, actual %h", hash_queue[0], out_hash_value);
            errors++;
          end
          void'(hash_queue.pop_front());
        end
      end
      if (in_valid && !in_stall) begin
        take_word(in_data_word, in_msg_length, in_first_word);
      end
      hashes_due = hash_queue.size();
    end
  end

endmodule

>>> test/multiply_rotate_hash_64_tb.sv
// Testbench top of the multiply-rotate 64-bit hash: stimulus, receiver pacing and verdict.
module multiply_rotate_hash_64_tb;

  // The random part is cut into phases; the configuration changes between them.
  localparam int PHASES = 8;
  localparam int PHASE_WORDS = 218;
  // The slowest word is one that closes a first half, so this covers any word still being
  // mixed when the last expected hash has come out.
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_OFF_CYCLES = 400;
  // About 1800 words, with stalls and phase drains, stay far below this.
  localparam int CYCLE_LIMIT = 1_000_000;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_write_en = 1'b0;
  logic [0:0]  cfg_index = mrh64_pkg::REG_SEED;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] in_data_word = '0;
  logic [31:0] in_msg_length = '0;
  logic        in_first_word = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_hash_value;

  int     mismatches;
  int     hashes_due;
  int     cycles = 0;
  int     phase_words;
  longint words_owed = 0;
  // When calm is set neither side idles. short_msgs keeps messages to a single word so
  // that hashes pile up, and squeeze asks the receiver for its long hold-off.
  bit     calm = 1'b0;
  bit     short_msgs = 1'b0;
  bit     squeeze = 1'b0;

  multiply_rotate_hash_64 dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_write_en  (cfg_write_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_word  (in_data_word),
    .in_msg_length (in_msg_length),
    .in_first_word (in_first_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_hash_value(out_hash_value)
  );

  mrh64_hash_checker watch (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_write_en  (cfg_write_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_word  (in_data_word),
    .in_msg_length (in_msg_length),
    .in_first_word (in_first_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_hash_value(out_hash_value),
    .errors        (mismatches),
    .hashes_due    (hashes_due)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Watchdog: a hash that never arrives or a stuck handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("multiply_rotate_hash_64_tb failed");
      $finish;
    end
  end

  // Receiver. It stalls at random unless calm is set. When squeeze is raised it holds
  // the output off for a long stretch while the sender keeps offering words, so the
  // block has to hold a finished hash and then stall its own input.
  initial begin
    forever begin
      @(posedge clk);
      if (squeeze) begin
        squeeze = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 35);
      end
    end
  end

  // Offers one word and returns at the clock edge where it is taken. A random idle gap
  // may come first; without one, valid simply stays high for the next word.
  task automatic send_word(input logic [63:0] data, input logic [31:0] len,
                           input logic first);
    int gap;
    gap = 0;
    while (!calm && $urandom_range(99) < 35) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_word  <= data;
    in_msg_length <= len;
    in_first_word <= first;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [63:0] pick_data();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return {$urandom, $urandom};
  endfunction

  // Lengths are mostly short; a few run over several 64-byte blocks, and now and then a
  // huge one is started that only a restart will end.
  function automatic logic [31:0] pick_length();
    int r;
    if (short_msgs) return $urandom_range(0, 8);
    r = $urandom_range(99);
    if (r < 1) return $urandom;
    if (r < 40) return $urandom_range(0, 15);
    if (r < 70) return $urandom_range(16, 130);
    if (r < 90) return $urandom_range(128, 300);
    return $urandom_range(300, 600);
  endfunction

  // Number of words after the first one that a message of this length still needs.
  function automatic longint words_after(input logic [31:0] len);
    if (len == 32'd0) return 0;
    return (longint'(len) + 7) / 8 - 1;
  endfunction

  // Starts a message and sends it to its end.
  task automatic send_msg(input logic [31:0] len);
    longint n;
    n = words_after(len);
    send_word(pick_data(), len, 1'b1);
    repeat (n) send_word(pick_data(), $urandom, 1'b0);
  endtask

  // Writes one register. The write enable drops at the next edge, before the task returns,
  // so back-to-back writes never touch the enable twice in one step.
  task automatic write_reg(input logic [0:0] idx, input logic [63:0] value);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    @(posedge clk);
  endtask

  // Lets every expected hash come out, then waits out any word still being mixed that
  // finishes no message. The block is idle after this.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (hashes_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [63:0] seed;
    int r;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, first with the reset configuration: a zero-length message whose
    // data must be ignored, a word while idle, the shortest and longest tails and one whole word.
    send_word('1, 32'd0, 1'b1);
    send_word(pick_data(), 32'hFFFF_FFFF, 1'b0);
    send_msg(32'd1);
    send_msg(32'd7);
    send_msg(32'd8);
    settle();

    // Swapped byte order with an all-ones seed: odd tails and one full 64-byte block,
    // which goes through both half-block mixers.
    write_reg(mrh64_pkg::REG_SEED, '1);
    write_reg(mrh64_pkg::REG_SWAP, 64'd1);
    send_msg(32'd7);
    send_msg(32'd3);
    send_msg(32'd64);

    // Restart: the longest possible length is dropped after two words by a new message.
    send_word('0, 32'hFFFF_FFFF, 1'b1);
    send_word('1, 32'd0, 1'b0);
    send_msg(32'd5);
    send_msg(32'd0);

    // Byte order changed in the middle of a message: the second word is read unswapped.
    send_word(pick_data(), 32'd12, 1'b1);
    settle();
    write_reg(mrh64_pkg::REG_SWAP, 64'd0);
    send_word(pick_data(), $urandom, 1'b0);

    // Random part. A phase may end in the middle of a message; the configuration then
    // changes under it and the next phase carries on with the remaining words.
    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: seed = '1;
        1: seed = '0;
        2: seed = 64'd1;
        7: seed = 64'h8000_0000_0000_0000;
        default: seed = {$urandom, $urandom};
      endcase
      write_reg(mrh64_pkg::REG_SEED, seed);
      write_reg(mrh64_pkg::REG_SWAP,
                (p == 0) ? 64'd1 : (p == 1) ? 64'd0 : 64'($urandom_range(1)));
      calm = (p == 5);
      short_msgs = (p == 3);
      if (p == 3) squeeze = 1'b1;
      phase_words = 0;
      while (phase_words < PHASE_WORDS || (p == PHASES - 1 && words_owed > 0)) begin
        r = $urandom_range(99);
        if (words_owed > 0 && r >= 3) begin
          send_word(pick_data(), $urandom, 1'b0);
          words_owed--;
          phase_words++;
        end else if (words_owed == 0 && r < 4) begin
          // Noise between messages; the block ignores it, so it is not counted.
          send_word(pick_data(), $urandom, 1'b0);
        end else begin
          begin
            logic [31:0] len;
            len = pick_length();
            send_word(pick_data(), len, 1'b1);
            words_owed = words_after(len);
          end
          phase_words++;
        end
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("multiply_rotate_hash_64_tb passed");
    end else begin
      $display("multiply_rotate_hash_64_tb failed");
    end
    $finish;
  end

endmodule
